// ----- hw/rtl/tjpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Two-joint PD controller package
// Shared word layouts, configuration fields and register codes.
// ----------------------------------------------------------------------------
package tjpd_pkg;

	localparam logic [1:0] REG_POSITION_GAIN    = 2'd0;
	localparam logic [1:0] REG_VELOCITY_GAIN    = 2'd1;
	localparam logic [1:0] REG_TARGET_ANGLE_ONE = 2'd2;
	localparam logic [1:0] REG_TARGET_ANGLE_TWO = 2'd3;

	typedef struct packed {
		logic        [15:0] position_gain;
		logic        [15:0] velocity_gain;
		logic signed [15:0] target_angle_one;
		logic signed [15:0] target_angle_two;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] joint_two_speed;
		logic signed [15:0] joint_one_speed;
		logic signed [15:0] joint_two_angle;
		logic signed [15:0] joint_one_angle;
	} sample_t;

	typedef struct packed {
		logic signed [36:0] pd_one;
		logic signed [36:0] pd_two;
		logic signed [16:0] err_one;
		logic signed [16:0] err_two;
	} pd_err_t;

	typedef struct packed {
		logic [14:0] mag_one;
		logic [14:0] mag_sum;
		logic        neg_one;
		logic        neg_sum;
	} sine_t;

	typedef struct packed {
		logic signed [16:0] error_two;
		logic signed [16:0] error_one;
		logic signed [31:0] torque_two;
		logic signed [31:0] torque_one;
	} result_t;

endpackage

// ----- hw/rtl/tjpd_front.sv -----
// ----------------------------------------------------------------------------
// Front end, stages one to three
// Forms angle phases, position errors, PD terms and sine table indexes.
// ----------------------------------------------------------------------------
module tjpd_front #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tjpd_pkg::cfg_t                        cfg,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  tjpd_pkg::sample_t                     in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [$clog2(4*SINE_TABLE_DEPTH)-1:0] idx_one,
	output logic [$clog2(4*SINE_TABLE_DEPTH)-1:0] idx_sum,
	output tjpd_pkg::pd_err_t                     out_data
);
	import tjpd_pkg::*;

	localparam int IW = $clog2(4*SINE_TABLE_DEPTH);
	localparam int MW = 32 + $clog2(4*SINE_TABLE_DEPTH + 1);
	localparam logic [31:0] TURNS_PER_RAD_Q20 = 32'd166886;

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	logic        [31:0] p_one_s1, p_two_s1;
	logic signed [16:0] e_one_s1, e_two_s1;
	logic signed [15:0] v_one_s1, v_two_s1;

	logic        [31:0] p_one_s2, p_sum_s2;
	logic signed [33:0] kpe_one_s2, kpe_two_s2;
	logic signed [32:0] kdv_one_s2, kdv_two_s2;
	logic signed [16:0] e_one_s2, e_two_s2;

	logic [IW-1:0] idx_one_s3, idx_sum_s3;
	pd_err_t       pd_s3;

	logic [MW-1:0] prod_one, prod_sum;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			p_one_s1 <= 32'(in_data.joint_one_angle) * TURNS_PER_RAD_Q20;
			p_two_s1 <= 32'(in_data.joint_two_angle) * TURNS_PER_RAD_Q20;
			e_one_s1 <= 17'(cfg.target_angle_one) - 17'(in_data.joint_one_angle);
			e_two_s1 <= 17'(cfg.target_angle_two) - 17'(in_data.joint_two_angle);
			v_one_s1 <= in_data.joint_one_speed;
			v_two_s1 <= in_data.joint_two_speed;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			p_one_s2   <= p_one_s1;
			p_sum_s2   <= p_one_s1 + p_two_s1;
			kpe_one_s2 <= 34'($signed({1'b0, cfg.position_gain})) * 34'(e_one_s1);
			kpe_two_s2 <= 34'($signed({1'b0, cfg.position_gain})) * 34'(e_two_s1);
			kdv_one_s2 <= 33'($signed({1'b0, cfg.velocity_gain})) * 33'(v_one_s1);
			kdv_two_s2 <= 33'($signed({1'b0, cfg.velocity_gain})) * 33'(v_two_s1);
			e_one_s2   <= e_one_s1;
			e_two_s2   <= e_two_s1;
		end
	end

	// The index is the top bits of phase times four table depths.
	always_comb begin
		prod_one = MW'(p_one_s2) * MW'(4*SINE_TABLE_DEPTH);
		prod_sum = MW'(p_sum_s2) * MW'(4*SINE_TABLE_DEPTH);
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			idx_one_s3     <= prod_one[32+IW-1:32];
			idx_sum_s3     <= prod_sum[32+IW-1:32];
			pd_s3.pd_one   <= 37'(kpe_one_s2) - (37'(kdv_one_s2) <<< 4);
			pd_s3.pd_two   <= 37'(kpe_two_s2) - (37'(kdv_two_s2) <<< 4);
			pd_s3.err_one  <= e_one_s2;
			pd_s3.err_two  <= e_two_s2;
		end
	end

	assign out_valid = v_s3;
	assign idx_one   = idx_one_s3;
	assign idx_sum   = idx_sum_s3;
	assign out_data  = pd_s3;

endmodule

// ----- hw/rtl/tjpd_sine.sv -----
// ----------------------------------------------------------------------------
// Sine lookup, stages four and five
// Folds each index into a quarter wave and reads the sine magnitude ROM.
// ----------------------------------------------------------------------------
module tjpd_sine #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [$clog2(4*SINE_TABLE_DEPTH)-1:0] idx_one,
	input  logic [$clog2(4*SINE_TABLE_DEPTH)-1:0] idx_sum,
	input  tjpd_pkg::pd_err_t                     in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output tjpd_pkg::sine_t                       out_sine,
	output tjpd_pkg::pd_err_t                     out_data
);
	import tjpd_pkg::*;

	localparam int IW = $clog2(4*SINE_TABLE_DEPTH);
	localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam logic [IW-1:0] QUARTER_ONE   = IW'(SINE_TABLE_DEPTH);
	localparam logic [IW-1:0] QUARTER_TWO   = IW'(2*SINE_TABLE_DEPTH);
	localparam logic [IW-1:0] QUARTER_THREE = IW'(3*SINE_TABLE_DEPTH);

	logic [14:0] sine_rom [SINE_TABLE_DEPTH+1];

	// Each entry is a six-term Taylor series in Q30, rounded to Q15.
	for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam longint unsigned X  = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
		localparam longint unsigned X2 = (X * X) >> 30;
		localparam longint unsigned T1 = ((X * X2) >> 30) / 6;
		localparam longint unsigned T2 = ((T1 * X2) >> 30) / 20;
		localparam longint unsigned T3 = ((T2 * X2) >> 30) / 42;
		localparam longint unsigned T4 = ((T3 * X2) >> 30) / 72;
		localparam longint unsigned T5 = ((T4 * X2) >> 30) / 110;
		localparam longint SUM = longint'(X) - longint'(T1) + longint'(T2)
			- longint'(T3) + longint'(T4) - longint'(T5);
		localparam longint POS = (SUM < 0) ? 64'sd0 : SUM;
		localparam longint QV  = (POS + 64'sd16384) >>> 15;
		localparam longint QS  = (QV > 64'sd32767) ? 64'sd32767 : QV;
		assign sine_rom[k] = 15'(QS);
	end

	function automatic logic [AW:0] fold(input logic [IW-1:0] idx);
		logic [IW-1:0] off;
		logic          odd;
		logic          neg;
		off = idx;
		odd = 1'b0;
		neg = 1'b0;
		if (idx >= QUARTER_THREE) begin
			off = idx - QUARTER_THREE;
			odd = 1'b1;
			neg = 1'b1;
		end else if (idx >= QUARTER_TWO) begin
			off = idx - QUARTER_TWO;
			neg = 1'b1;
		end else if (idx >= QUARTER_ONE) begin
			off = idx - QUARTER_ONE;
			odd = 1'b1;
		end
		if (odd) begin
			off = QUARTER_ONE - off;
		end
		return {neg, off[AW-1:0]};
	endfunction

	logic v_s4, v_s5;
	logic en_s4, en_s5;

	logic [AW-1:0] addr_one_s4, addr_sum_s4;
	logic          neg_one_s4, neg_sum_s4;
	pd_err_t       pd_s4;

	sine_t   sine_s5;
	pd_err_t pd_s5;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign in_ready = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s4) begin
				v_s4 <= in_valid;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			{neg_one_s4, addr_one_s4} <= fold(idx_one);
			{neg_sum_s4, addr_sum_s4} <= fold(idx_sum);
			pd_s4                     <= in_data;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			sine_s5.mag_one <= sine_rom[addr_one_s4];
			sine_s5.mag_sum <= sine_rom[addr_sum_s4];
			sine_s5.neg_one <= neg_one_s4;
			sine_s5.neg_sum <= neg_sum_s4;
			pd_s5           <= pd_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_sine  = sine_s5;
	assign out_data  = pd_s5;

endmodule

// ----- hw/rtl/tjpd_torque.sv -----
// ----------------------------------------------------------------------------
// Torque back end, stages six to nine
// Scales the sines into gravity terms, subtracts them and rounds to Q23.8.
// ----------------------------------------------------------------------------
module tjpd_torque (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tjpd_pkg::sine_t   in_sine,
	input  tjpd_pkg::pd_err_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output tjpd_pkg::result_t out_data
);
	import tjpd_pkg::*;

	localparam logic signed [35:0] GRAV_ONE_Q16 = 36'sd482181;
	localparam logic signed [35:0] GRAV_TWO_Q16 = 36'sd160727;
	localparam logic signed [55:0] ROUND_HALF   = 56'sd4194304;
	localparam logic signed [32:0] TORQUE_MAX   = 33'sd2147483647;
	localparam logic signed [32:0] TORQUE_MIN   = -33'sd2147483648;

	function automatic logic signed [31:0] saturate(input logic signed [32:0] v);
		logic signed [31:0] r;
		r = v[31:0];
		if (v > TORQUE_MAX) begin
			r = TORQUE_MAX[31:0];
		end else if (v < TORQUE_MIN) begin
			r = TORQUE_MIN[31:0];
		end
		return r;
	endfunction

	logic v_s6, v_s7, v_s8, v_s9;
	logic en_s6, en_s7, en_s8, en_s9;

	logic signed [15:0] sin_one, sin_sum;

	logic signed [35:0] g_one_s6, g_sum_s6;
	pd_err_t            pd_s6;
	logic signed [35:0] g_one_s7, g_two_s7;
	pd_err_t            pd_s7;
	logic signed [55:0] t_one_s8, t_two_s8;
	logic signed [16:0] err_one_s8, err_two_s8;
	result_t            res_s9;

	assign en_s9    = !v_s9 || out_ready;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign en_s6    = !v_s6 || en_s7;
	assign in_ready = en_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (en_s6) begin
				v_s6 <= in_valid;
			end
			if (en_s7) begin
				v_s7 <= v_s6;
			end
			if (en_s8) begin
				v_s8 <= v_s7;
			end
			if (en_s9) begin
				v_s9 <= v_s8;
			end
		end
	end

	always_comb begin
		sin_one = in_sine.neg_one ? -$signed({1'b0, in_sine.mag_one})
			: $signed({1'b0, in_sine.mag_one});
		sin_sum = in_sine.neg_sum ? -$signed({1'b0, in_sine.mag_sum})
			: $signed({1'b0, in_sine.mag_sum});
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			g_one_s6 <= 36'(sin_one) * GRAV_ONE_Q16;
			g_sum_s6 <= 36'(sin_sum) * GRAV_TWO_Q16;
			pd_s6    <= in_data;
		end
		if (en_s7) begin
			g_one_s7 <= g_one_s6 + g_sum_s6;
			g_two_s7 <= g_sum_s6;
			pd_s7    <= pd_s6;
		end
		if (en_s8) begin
			t_one_s8   <= (56'(pd_s7.pd_one) <<< 15) - 56'(g_one_s7) + ROUND_HALF;
			t_two_s8   <= (56'(pd_s7.pd_two) <<< 15) - 56'(g_two_s7) + ROUND_HALF;
			err_one_s8 <= pd_s7.err_one;
			err_two_s8 <= pd_s7.err_two;
		end
		if (en_s9) begin
			res_s9.torque_one <= saturate(t_one_s8[55:23]);
			res_s9.torque_two <= saturate(t_two_s8[55:23]);
			res_s9.error_one  <= err_one_s8;
			res_s9.error_two  <= err_two_s8;
		end
	end

	assign out_valid = v_s9;
	assign out_data  = res_s9;

endmodule

// ----- hw/rtl/two_joint_pd_gravity_comp_top.sv -----
// ----------------------------------------------------------------------------
// Two-joint PD controller with gravity compensation
// Computes saturated joint torques and position errors for a two-link arm.
// ----------------------------------------------------------------------------
// The block takes one sensor word per clock and returns one result word per
// clock while the output is not stalled. A result word is presented once
// its sample has passed all nine pipeline stages, which hold the phase
// products, the PD products, the index multiply, quarter-wave folding, the
// registered sine ROM read (two ports, one per sine), the gravity products,
// the gravity sum, the subtraction and rounding, and the output register.
// A stalled output holds its word while bubbles further up still fill.
// There is no clearing pass after reset.
module two_joint_pd_gravity_comp_top #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// joint_one_angle, joint_two_angle, joint_one_speed, joint_two_speed
	input  logic [63:0]  s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// torque_one, torque_two, error_one, error_two, zero fill
	output logic [103:0] m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import tjpd_pkg::*;

	localparam int IW = $clog2(4*SINE_TABLE_DEPTH);

	cfg_t    cfg_q;
	logic    cfg_write;

	logic          front_valid, front_ready;
	logic [IW-1:0] idx_one, idx_sum;
	pd_err_t       front_data;
	logic          sine_valid, sine_ready;
	sine_t         sine_data;
	pd_err_t       sine_pd;
	result_t       result;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.position_gain    <= 16'd3200;
			cfg_q.velocity_gain    <= 16'd160;
			cfg_q.target_angle_one <= 16'sd4096;
			cfg_q.target_angle_two <= 16'sd4096;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_POSITION_GAIN:    cfg_q.position_gain    <= pwdata[15:0];
				REG_VELOCITY_GAIN:    cfg_q.velocity_gain    <= pwdata[15:0];
				REG_TARGET_ANGLE_ONE: cfg_q.target_angle_one <= pwdata[15:0];
				REG_TARGET_ANGLE_TWO: cfg_q.target_angle_two <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_POSITION_GAIN:    prdata = {16'd0, cfg_q.position_gain};
			REG_VELOCITY_GAIN:    prdata = {16'd0, cfg_q.velocity_gain};
			REG_TARGET_ANGLE_ONE: prdata = 32'(cfg_q.target_angle_one);
			REG_TARGET_ANGLE_TWO: prdata = 32'(cfg_q.target_angle_two);
			default:              prdata = 32'd0;
		endcase
	end

	tjpd_front #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_data  (sample_t'(s_tdata)),
		.out_valid(front_valid),
		.out_ready(front_ready),
		.idx_one  (idx_one),
		.idx_sum  (idx_sum),
		.out_data (front_data)
	);

	tjpd_sine #(
		.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
	) u_sine (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_ready (front_ready),
		.idx_one  (idx_one),
		.idx_sum  (idx_sum),
		.in_data  (front_data),
		.out_valid(sine_valid),
		.out_ready(sine_ready),
		.out_sine (sine_data),
		.out_data (sine_pd)
	);

	tjpd_torque u_torque (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sine_valid),
		.in_ready (sine_ready),
		.in_sine  (sine_data),
		.in_data  (sine_pd),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (result)
	);

	assign m_tdata = {6'd0, result};

	// An empty output stage means every stage can advance.
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output stage is empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without an output stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_write && paddr[3:2] == REG_POSITION_GAIN)
		|=> cfg_q.position_gain == $past(pwdata[15:0]))
		else $error("position gain write lost");

	assert property (@(posedge clk) disable iff (!arst_n)
		(psel && !pwrite && paddr[3:2] == REG_VELOCITY_GAIN)
		|-> prdata == {16'd0, cfg_q.velocity_gain})
		else $error("velocity gain read mismatch");

endmodule
